### hw/rtl/mvm_pkg.sv
// Shared types and constants for the voice mixer.
`timescale 1ns / 1ps
package mvm_pkg;

  localparam int SMP_W  = 16;
  localparam int ADDR_W = 16;
  localparam int LEN_W  = 17;

  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_QUEUE = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_QSCAN,
    ST_TREAD,
    ST_TADDR,
    ST_TACC,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [LEN_W-1:0]  length;
    logic [LEN_W-1:0]  pos;
  } voice_t;

  typedef struct packed {
    logic              has_sample;
    logic              ends;
    logic [LEN_W-1:0]  pos_inc;
    logic [SMP_W-1:0]  sum;
  } alu_res_t;

endpackage

### hw/rtl/mvm_sample_ram.sv
// Sample memory: one write port, one registered read port.
`timescale 1ns / 1ps
module mvm_sample_ram
  import mvm_pkg::*;
#(
  parameter int DEPTH = 65536,
  parameter int AW    = 16
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [SMP_W-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [SMP_W-1:0] rdata
);

  logic [SMP_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/mvm_voice_ram.sv
// Voice table: start, length and position per slot, registered read.
`timescale 1ns / 1ps
module mvm_voice_ram
  import mvm_pkg::*;
#(
  parameter int VOICES = 30,
  parameter int IW     = 5
) (
  input  logic          clk,
  input  logic          we,
  input  logic [IW-1:0] waddr,
  input  voice_t        wdata,
  input  logic [IW-1:0] raddr,
  output voice_t        rdata
);

  voice_t mem [VOICES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/mvm_mix_alu.sv
// Shared mix unit: saturating accumulate and position advance for one voice.
`timescale 1ns / 1ps
module mvm_mix_alu
  import mvm_pkg::*;
(
  input  logic [SMP_W-1:0] acc,
  input  logic [SMP_W-1:0] sample,
  input  logic [LEN_W-1:0] pos,
  input  logic [LEN_W-1:0] length,
  output alu_res_t         res
);

  logic [SMP_W:0] s;

  always_comb begin
    s = {acc[SMP_W-1], acc} + {sample[SMP_W-1], sample};
    if (s[SMP_W] != s[SMP_W-1]) begin
      res.sum = s[SMP_W] ? {1'b1, {(SMP_W-1){1'b0}}} : {1'b0, {(SMP_W-1){1'b1}}};
    end else begin
      res.sum = s[SMP_W-1:0];
    end
    res.has_sample = (pos < length);
    // pos < length here, so the increment cannot wrap
    res.pos_inc    = pos + LEN_W'(1);
    res.ends       = (res.pos_inc >= length);
  end

endmodule

### hw/rtl/multi_voice_saturating_mixer.sv
// Steps: write or unknown action goes straight to hand-over; queue checks one slot per cycle,
// top down; tick visits each slot in turn, skips idle ones, and for an active voice reads the
// table, reads the sample and accumulates (a zero-length sound is freed after the table read);
// then the result is handed over. One item at a time; the result register frees the input.
// Throughput set by the single mix unit and the one read port of voice table and sample memory.
// Reset clears active bits, voice count, sequencer and result valid; memories stay unknown.
`timescale 1ns / 1ps
module multi_voice_saturating_mixer
  import mvm_pkg::*;
#(
  parameter int VOICES           = 30,
  parameter int SAMPLE_MEM_DEPTH = 65536
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              action,
  input  logic [ADDR_W-1:0]       address,
  input  logic signed [SMP_W-1:0] sample_value,
  input  logic [LEN_W-1:0]        sound_length,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [SMP_W-1:0] mixed_sample,
  output logic                    queue_accepted,
  output logic [4:0]              slot_index,
  output logic [4:0]              active_voices
);

  localparam int IW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int CW = $clog2(VOICES + 1);
  localparam int AW = $clog2(SAMPLE_MEM_DEPTH);
  localparam logic [IW-1:0] LAST = IW'(VOICES - 1);

  state_t              state, state_next;
  logic [IW-1:0]       idx, idx_next;
  logic [SMP_W-1:0]    acc, acc_next;
  logic                q_ok, q_ok_next;
  logic [IW-1:0]       q_slot, q_slot_next;
  logic [CW-1:0]       count, count_next;
  logic [VOICES-1:0]   active, active_next;
  logic                load_out;
  logic [ADDR_W-1:0]   q_addr;
  logic [LEN_W-1:0]    q_len;

  logic                vt_we;
  voice_t              vt_wdata, vt_rdata;
  logic                sm_we;
  logic [AW-1:0]       sm_waddr, sm_raddr;
  logic [SMP_W-1:0]    sm_rdata;
  logic [19:0]         waddr_ext, raddr_ext;
  alu_res_t            alu;
  logic                accept;
  logic [6:0]          count_ext;
  logic [5:0]          slot_ext;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state == ST_IDLE);
  assign waddr_ext = 20'(address);
  assign sm_waddr  = waddr_ext[AW-1:0];
  assign raddr_ext = 20'(vt_rdata.start) + 20'(vt_rdata.pos);
  assign sm_raddr  = raddr_ext[AW-1:0];
  assign sm_we     = accept && (action == ACT_WRITE);

  mvm_sample_ram #(.DEPTH(SAMPLE_MEM_DEPTH), .AW(AW)) u_sample_ram (
    .clk  (clk),
    .we   (sm_we),
    .waddr(sm_waddr),
    .wdata(sample_value),
    .raddr(sm_raddr),
    .rdata(sm_rdata)
  );

  mvm_voice_ram #(.VOICES(VOICES), .IW(IW)) u_voice_ram (
    .clk  (clk),
    .we   (vt_we),
    .waddr(idx),
    .wdata(vt_wdata),
    .raddr(idx),
    .rdata(vt_rdata)
  );

  mvm_mix_alu u_alu (
    .acc   (acc),
    .sample(sm_rdata),
    .pos   (vt_rdata.pos),
    .length(vt_rdata.length),
    .res   (alu)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      count  <= '0;
      active <= '0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      active <= active_next;
    end
    idx    <= idx_next;
    acc    <= acc_next;
    q_ok   <= q_ok_next;
    q_slot <= q_slot_next;
    // the slot scan runs after the request is gone from the ports
    if (accept) begin
      q_addr <= address;
      q_len  <= sound_length;
    end
  end

  always_comb begin
    state_next  = state;
    idx_next    = idx;
    acc_next    = acc;
    q_ok_next   = q_ok;
    q_slot_next = q_slot;
    count_next  = count;
    active_next = active;
    vt_we       = 1'b0;
    vt_wdata    = vt_rdata;
    load_out    = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          acc_next    = '0;
          q_ok_next   = 1'b0;
          q_slot_next = '0;
          priority if (action == ACT_QUEUE) begin
            idx_next   = LAST;
            state_next = ST_QSCAN;
          end else if (action == ACT_TICK) begin
            idx_next   = '0;
            state_next = ST_TREAD;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_QSCAN: begin
        if (!active[idx]) begin
          active_next[idx] = 1'b1;
          count_next       = count + CW'(1);
          vt_we            = 1'b1;
          vt_wdata.start   = q_addr;
          vt_wdata.length  = q_len;
          vt_wdata.pos     = '0;
          q_ok_next        = 1'b1;
          q_slot_next      = idx;
          state_next       = ST_DONE;
        end else if (idx == '0) begin
          state_next = ST_DONE;
        end else begin
          idx_next = idx - IW'(1);
        end
      end
      ST_TREAD: begin
        if (active[idx]) begin
          state_next = ST_TADDR;
        end else if (idx == LAST) begin
          state_next = ST_DONE;
        end else begin
          idx_next = idx + IW'(1);
        end
      end
      ST_TADDR: begin
        if (alu.has_sample) begin
          state_next = ST_TACC;
        end else begin
          // nothing left to play: free the slot
          active_next[idx] = 1'b0;
          count_next       = count - CW'(1);
          vt_we            = 1'b1;
          vt_wdata.pos     = '0;
          if (idx == LAST) begin
            state_next = ST_DONE;
          end else begin
            idx_next   = idx + IW'(1);
            state_next = ST_TREAD;
          end
        end
      end
      ST_TACC: begin
        acc_next = alu.sum;
        vt_we    = 1'b1;
        if (alu.ends) begin
          active_next[idx] = 1'b0;
          count_next       = count - CW'(1);
          vt_wdata.pos     = '0;
        end else begin
          vt_wdata.pos = alu.pos_inc;
        end
        if (idx == LAST) begin
          state_next = ST_DONE;
        end else begin
          idx_next   = idx + IW'(1);
          state_next = ST_TREAD;
        end
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign count_ext = 7'(count);
  assign slot_ext  = 6'(q_slot);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (load_out) begin
      mixed_sample   <= acc;
      queue_accepted <= q_ok;
      slot_index     <= slot_ext[4:0];
      active_voices  <= count_ext[4:0];
    end
  end

endmodule

### dv/mvm_mix_checker.sv
// Checker for the voice mixer: predicts each result and compares it with the block output.
`timescale 1ns / 1ps
module mvm_mix_checker
  import mvm_pkg::*;
#(
  parameter int VOICES           = 30,
  parameter int SAMPLE_MEM_DEPTH = 65536
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic [1:0]              action,
  input  logic [ADDR_W-1:0]       address,
  input  logic signed [SMP_W-1:0] sample_value,
  input  logic [LEN_W-1:0]        sound_length,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic signed [SMP_W-1:0] mixed_sample,
  input  logic                    queue_accepted,
  input  logic [4:0]              slot_index,
  input  logic [4:0]              active_voices,
  output int                      error_count,
  output int                      pending_results
);

  localparam int MEM_AW = $clog2(SAMPLE_MEM_DEPTH);

  typedef struct packed {
    logic signed [SMP_W-1:0] mixed;
    logic                    accepted;
    logic [4:0]              slot;
    logic [4:0]              voices;
  } mix_result_t;

  logic              voice_on  [VOICES];
  logic [ADDR_W-1:0] voice_base[VOICES];
  logic [LEN_W-1:0]  voice_len [VOICES];
  logic [LEN_W-1:0]  voice_pos [VOICES];
  logic [SMP_W-1:0]  pcm_mem   [SAMPLE_MEM_DEPTH];
  mix_result_t       mix_expected_q[$];

  function automatic mix_result_t mix_request(input logic [1:0] act,
                                              input logic [ADDR_W-1:0] addr,
                                              input logic [SMP_W-1:0] val,
                                              input logic [LEN_W-1:0] n);
    mix_result_t r;
    int          sum;
    int          smp;
    int          cnt;
    int          i;
    r   = '0;
    sum = 0;
    cnt = 0;
    case (act)
      ACT_WRITE: pcm_mem[MEM_AW'(int'(addr) % SAMPLE_MEM_DEPTH)] = val;
      ACT_QUEUE: begin
        // highest free slot wins
        for (i = VOICES - 1; i >= 0; i--) begin
          if (!voice_on[i]) begin
            voice_on[i]   = 1'b1;
            voice_base[i] = addr;
            voice_len[i]  = n;
            voice_pos[i]  = '0;
            r.accepted    = 1'b1;
            r.slot        = i[4:0];
            break;
          end
        end
      end
      ACT_TICK: begin
        for (i = 0; i < VOICES; i++) begin
          if (voice_on[i]) begin
            if (voice_pos[i] < voice_len[i]) begin
              smp = int'($signed(pcm_mem[MEM_AW'((int'(voice_base[i]) + int'(voice_pos[i]))
                                                 % SAMPLE_MEM_DEPTH)]));
              sum = sum + smp;
              if (sum > 32767) sum = 32767;
              else if (sum < -32768) sum = -32768;
              voice_pos[i] = voice_pos[i] + LEN_W'(1);
            end
            // zero-length sounds fall straight through to here
            if (voice_pos[i] >= voice_len[i]) begin
              voice_on[i]  = 1'b0;
              voice_pos[i] = '0;
            end
          end
        end
      end
      default: ;
    endcase
    for (i = 0; i < VOICES; i++) if (voice_on[i]) cnt++;
    r.mixed  = sum[SMP_W-1:0];
    r.voices = cnt[4:0];
    return r;
  endfunction

  task automatic flag_mismatch(input string field, input int want_v, input int got_v);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want_v, got_v);
    error_count++;
  endtask

  always @(posedge clk) begin : monitor
    mix_result_t want;
    int          i;
    if (rst) begin
      for (i = 0; i < VOICES; i++) begin
        voice_on[i]  = 1'b0;
        voice_pos[i] = '0;
      end
      mix_expected_q.delete();
      error_count = 0;
    end else begin
      // results never appear in the cycle their request is accepted, so pop before push
      if (out_valid && out_ready) begin
        if (mix_expected_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual mix %0d slot %0d voices %0d",
                   $time, mixed_sample, slot_index, active_voices);
          error_count++;
        end else begin
          want = mix_expected_q.pop_front();
          if (mixed_sample !== want.mixed)
            flag_mismatch("mixed_sample", int'(want.mixed), int'(mixed_sample));
          if (queue_accepted !== want.accepted)
            flag_mismatch("queue_accepted", int'(want.accepted), int'(queue_accepted));
          if (slot_index !== want.slot)
            flag_mismatch("slot_index", int'(want.slot), int'(slot_index));
          if (active_voices !== want.voices)
            flag_mismatch("active_voices", int'(want.voices), int'(active_voices));
        end
      end
      if (in_valid && in_ready)
        mix_expected_q.push_back(mix_request(action, address, sample_value, sound_length));
    end
    pending_results = mix_expected_q.size();
  end

endmodule

### dv/tb_multi_voice_saturating_mixer.sv
// Testbench top for the voice mixer: clock, reset, request stimulus, pacing and verdict.
`timescale 1ns / 1ps
module tb_multi_voice_saturating_mixer;
  import mvm_pkg::*;

  localparam int VOICES           = 30;
  localparam int SAMPLE_MEM_DEPTH = 65536;
  localparam int NUM_REQUESTS     = 1300;
  localparam int STALL_LIMIT      = 2000;
  localparam int DRAIN_CYCLES     = 150;
  localparam logic [1:0] ACT_NONE = 2'd3;  // undefined action, block leaves voices and memory alone

  logic                    clk          = 1'b0;
  logic                    rst          = 1'b1;
  logic                    in_valid     = 1'b0;
  logic                    in_ready;
  logic [1:0]              action       = ACT_WRITE;
  logic [ADDR_W-1:0]       address      = '0;
  logic signed [SMP_W-1:0] sample_value = '0;
  logic [LEN_W-1:0]        sound_length = '0;
  logic                    out_valid;
  logic                    out_ready    = 1'b0;
  logic signed [SMP_W-1:0] mixed_sample;
  logic                    queue_accepted;
  logic [4:0]              slot_index;
  logic [4:0]              active_voices;

  int   error_count;
  int   pending_results;
  int   requests_sent = 0;
  int   stall_cycles  = 0;
  logic calm;

  // slot occupancy as seen by stimulus: every sample a voice is about to read gets written
  bit              slot_busy[VOICES];
  bit [ADDR_W-1:0] slot_base[VOICES];
  bit [LEN_W-1:0]  slot_len [VOICES];
  bit [LEN_W-1:0]  slot_pos [VOICES];
  bit              written  [SAMPLE_MEM_DEPTH];

  always #10 clk = ~clk;

  assign calm = (requests_sent >= 400) && (requests_sent < 650);

  multi_voice_saturating_mixer #(
    .VOICES          (VOICES),
    .SAMPLE_MEM_DEPTH(SAMPLE_MEM_DEPTH)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .action        (action),
    .address       (address),
    .sample_value  (sample_value),
    .sound_length  (sound_length),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .mixed_sample  (mixed_sample),
    .queue_accepted(queue_accepted),
    .slot_index    (slot_index),
    .active_voices (active_voices)
  );

  mvm_mix_checker #(
    .VOICES          (VOICES),
    .SAMPLE_MEM_DEPTH(SAMPLE_MEM_DEPTH)
  ) i_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .action         (action),
    .address        (address),
    .sample_value   (sample_value),
    .sound_length   (sound_length),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .mixed_sample   (mixed_sample),
    .queue_accepted (queue_accepted),
    .slot_index     (slot_index),
    .active_voices  (active_voices),
    .error_count    (error_count),
    .pending_results(pending_results)
  );

  always @(negedge clk) begin
    out_ready <= calm || ($urandom_range(0, 99) >= 16);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // lean toward full-scale values so sums saturate often
  function automatic logic [SMP_W-1:0] pick_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return 16'h7FFF;
    if (r < 30) return 16'h8000;
    if (r < 45) return SMP_W'($urandom_range(0, 15) - 8);
    return SMP_W'($urandom_range(0, 65535));
  endfunction

  // mostly short sounds; very long ones hold a slot for the rest of the run
  function automatic logic [LEN_W-1:0] pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return '0;
    if (r < 75) return LEN_W'($urandom_range(1, 16));
    if (r < 96) return LEN_W'($urandom_range(17, 400));
    if (r < 97) return 17'd65536;
    if (r < 98) return LEN_W'($urandom_range(65537, 131071));
    return LEN_W'($urandom_range(401, 65535));
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic push_request(input logic [1:0] act, input logic [ADDR_W-1:0] addr,
                              input logic [SMP_W-1:0] val, input logic [LEN_W-1:0] n);
    while (!calm && $urandom_range(0, 99) < 16) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    action       <= act;
    address      <= addr;
    sample_value <= val;
    sound_length <= n;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    if (act != ACT_NONE) requests_sent++;
  endtask

  task automatic write_sample(input logic [ADDR_W-1:0] addr, input logic [SMP_W-1:0] val);
    push_request(ACT_WRITE, addr, val, LEN_W'($urandom_range(0, 131071)));
    written[addr] = 1'b1;
  endtask

  task automatic queue_sound(input logic [ADDR_W-1:0] addr, input logic [LEN_W-1:0] n);
    int i;
    push_request(ACT_QUEUE, addr, SMP_W'($urandom_range(0, 65535)), n);
    for (i = VOICES - 1; i >= 0; i--) begin
      if (!slot_busy[i]) begin
        slot_busy[i] = 1'b1;
        slot_base[i] = addr;
        slot_len[i]  = n;
        slot_pos[i]  = '0;
        break;
      end
    end
  endtask

  task automatic run_tick();
    int              i;
    logic [ADDR_W-1:0] a;
    for (i = 0; i < VOICES; i++) begin
      if (slot_busy[i] && slot_pos[i] < slot_len[i]) begin
        a = slot_base[i] + slot_pos[i][ADDR_W-1:0];
        if (!written[a]) write_sample(a, pick_sample());
      end
    end
    push_request(ACT_TICK, ADDR_W'($urandom_range(0, 65535)),
                 SMP_W'($urandom_range(0, 65535)), LEN_W'($urandom_range(0, 131071)));
    for (i = 0; i < VOICES; i++) begin
      if (slot_busy[i]) begin
        if (slot_pos[i] < slot_len[i]) slot_pos[i] = slot_pos[i] + LEN_W'(1);
        if (slot_pos[i] >= slot_len[i]) begin
          slot_busy[i] = 1'b0;
          slot_pos[i]  = '0;
        end
      end
    end
  endtask

  // one more sound than there are slots, so the last is rejected at least once
  task automatic queue_flood();
    repeat (VOICES + 1) begin
      queue_sound(ADDR_W'($urandom_range(0, 65535)), LEN_W'($urandom_range(1, 6)));
    end
    repeat (6) run_tick();
  endtask

  initial begin
    int              pick;
    int              k;
    int              burst;
    logic [ADDR_W-1:0] base;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: field extremes, wrap at the top of memory, zero and maximum length,
    // saturation both ways, unknown action
    write_sample(16'hFFFF, 16'h7FFF);
    write_sample(16'h0000, 16'h7FFF);
    write_sample(16'h0001, 16'h8000);
    write_sample(16'h0002, 16'h0000);
    write_sample(16'h8000, 16'hFFFF);
    queue_sound(16'hFFFF, 17'd3);
    queue_sound(16'h0000, 17'd0);
    queue_sound(16'hFFFF, 17'h1FFFF);
    run_tick();
    run_tick();
    run_tick();
    push_request(ACT_NONE, 16'hFFFF, 16'h7FFF, 17'h1FFFF);
    run_tick();
    queue_sound(16'h8000, 17'd65536);
    run_tick();
    run_tick();

    // random: load-then-play sequences, with noise mixed in
    queue_flood();
    while (requests_sent < NUM_REQUESTS) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        base  = ADDR_W'($urandom_range(0, 65535));
        burst = $urandom_range(1, 12);
        for (k = 0; k < burst; k++) write_sample(base + ADDR_W'(k), pick_sample());
        queue_sound(base, pick_length());
        repeat ($urandom_range(1, 4)) run_tick();
      end else if (pick < 55) begin
        repeat ($urandom_range(1, 8)) run_tick();
      end else if (pick < 70) begin
        write_sample(ADDR_W'($urandom_range(0, 65535)), pick_sample());
      end else if (pick < 85) begin
        queue_sound(ADDR_W'($urandom_range(0, 65535)), pick_length());
      end else if (pick < 88) begin
        queue_flood();
      end else if (pick < 91) begin
        push_request(ACT_NONE, ADDR_W'($urandom_range(0, 65535)),
                     SMP_W'($urandom_range(0, 65535)), LEN_W'($urandom_range(0, 131071)));
      end else begin
        // sound queued over memory not loaded yet; run_tick fills it just in time
        queue_sound(ADDR_W'($urandom_range(0, 65535)), pick_length());
        run_tick();
      end
    end
    in_valid <= 1'b0;

    while (pending_results != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_results == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/mvm_pkg.sv
hw/rtl/mvm_sample_ram.sv
hw/rtl/mvm_voice_ram.sv
hw/rtl/mvm_mix_alu.sv
hw/rtl/multi_voice_saturating_mixer.sv
dv/mvm_mix_checker.sv
dv/tb_multi_voice_saturating_mixer.sv
